// File: sv/hslm_pkg.sv
// shared types, constants and heading helpers for the heading sector lift map
package hslm_pkg;

  // heading arithmetic, tenths of a degree
  localparam int HEADING_W = 12;
  localparam logic [11:0] FULL_TURN = 12'd3600;
  localparam logic [11:0] STEP = 12'd100;
  localparam logic [11:0] LAST_STEP_START = 12'd3500;
  localparam logic [12:0] HALF_STEP = 13'd50;
  localparam logic [12:0] FULL_TURN_W = 13'd3600;
  localparam logic [11:0] NORTH_LOW = 12'd900;
  localparam logic [11:0] NORTH_HIGH = 12'd2700;
  localparam logic signed [12:0] HALF_TURN_S = 13'sd1800;
  localparam logic signed [12:0] FULL_TURN_S = 13'sd3600;

  // sector table
  localparam int SECTORS = 36;
  localparam int SECTOR_W = 6;
  localparam logic [5:0] LAST_SECTOR = 6'd35;
  localparam int SECTOR_SUM_GROWTH = 6;

  // divide by 100 through a reciprocal, exact for values below 3600
  localparam logic [12:0] RECIP_100 = 13'd5243;

  // mean over the sectors: magnitude shifted right by two, then a chunked
  // multiply by a reciprocal of 9
  localparam int AVG_PRE_SHIFT = 2;
  localparam int MUL_CHUNK_W = 16;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // one classified sample
  typedef struct packed {
    logic [11:0] heading;
    logic [11:0] start;
    logic        left;
    logic        clear;
    logic        north;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SWEEP,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } back_state_t;

  // sector index of a heading below a full turn
  function automatic logic [5:0] sector_of(input logic [11:0] h);
    logic [12:0] s;
    logic [11:0] hp;
    logic [24:0] prod;
    logic [5:0]  idx;
    s = {1'b0, h} + HALF_STEP;
    hp = (s >= FULL_TURN_W) ? 12'(s - FULL_TURN_W) : s[11:0];
    prod = 25'(hp) * 25'(RECIP_100);
    idx = prod[24:19];
    sector_of = (idx > LAST_SECTOR) ? LAST_SECTOR : idx;
  endfunction

  // difference to - from, wrapped into (-1800, 1800]
  function automatic logic signed [12:0] wrapped_delta(input logic [11:0] to,
                                                       input logic [11:0] from);
    logic signed [12:0] d;
    d = $signed({1'b0, to}) - $signed({1'b0, from});
    if (d <= -HALF_TURN_S) begin
      d = d + FULL_TURN_S;
    end else if (d > HALF_TURN_S) begin
      d = d - FULL_TURN_S;
    end
    wrapped_delta = d;
  endfunction

  // one sweep step in the turn direction, wrapping at north
  function automatic logic [11:0] step_heading(input logic [11:0] h, input logic left);
    if (left) begin
      step_heading = (h < STEP) ? h + LAST_STEP_START : h - STEP;
    end else begin
      step_heading = (h >= LAST_STEP_START) ? h - LAST_STEP_START : h + STEP;
    end
  endfunction

endpackage

// File: sv/hslm_front.sv
// front end: accepts samples, tracks previous heading and circling, classifies
module hslm_front #(
  parameter int LIFT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [11:0]                  in_heading,
  input  logic signed [LIFT_WIDTH-1:0] in_lift,
  input  logic                         in_circling,
  input  logic                         in_turning_left,
  input  logic                         q_full,
  output logic                         push,
  output hslm_pkg::cmd_t               cmd,
  output logic signed [LIFT_WIDTH-1:0] lift
);

  logic [11:0] prev_heading_r, prev_heading_nxt;
  logic        prev_circling_r, prev_circling_nxt;
  logic [11:0] heading_n;

  // fold out-of-range headings back below a full turn
  assign heading_n = (in_heading >= hslm_pkg::FULL_TURN) ?
                     in_heading - hslm_pkg::FULL_TURN : in_heading;

  // take a word whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // classify the sample
  always_comb begin
    cmd.heading = heading_n;
    cmd.start   = prev_heading_r;
    cmd.left    = in_turning_left;
    cmd.clear   = !in_circling && prev_circling_r;
    cmd.north   = (heading_n < hslm_pkg::NORTH_LOW && prev_heading_r > hslm_pkg::NORTH_HIGH) ||
                  (prev_heading_r < hslm_pkg::NORTH_LOW && heading_n > hslm_pkg::NORTH_HIGH);
    lift        = in_lift;
  end

  // history for the next sample
  always_comb begin
    prev_heading_nxt  = prev_heading_r;
    prev_circling_nxt = prev_circling_r;
    if (push) begin
      prev_heading_nxt  = heading_n;
      prev_circling_nxt = in_circling;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_heading_r  <= '0;
      prev_circling_r <= 1'b0;
    end else begin
      prev_heading_r  <= prev_heading_nxt;
      prev_circling_r <= prev_circling_nxt;
    end
  end

endmodule

// File: sv/hslm_queue.sv
// short command queue between the front and back ends
module hslm_queue #(
  parameter int LIFT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  hslm_pkg::cmd_t               cmd_in,
  input  logic signed [LIFT_WIDTH-1:0] lift_in,
  input  logic                         pop,
  output hslm_pkg::cmd_t               cmd_out,
  output logic signed [LIFT_WIDTH-1:0] lift_out,
  output logic                         full,
  output logic                         empty
);

  hslm_pkg::cmd_t              cmd_q_r  [hslm_pkg::QUEUE_DEPTH];
  logic signed [LIFT_WIDTH-1:0] lift_q_r [hslm_pkg::QUEUE_DEPTH];
  logic [hslm_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hslm_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [hslm_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == hslm_pkg::QCNT_W'(hslm_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign cmd_out  = cmd_q_r[rd_ptr_r];
  assign lift_out = lift_q_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q_r[wr_ptr_r]  <= cmd_in;
      lift_q_r[wr_ptr_r] <= lift_in;
    end
  end

endmodule

// File: sv/hslm_back.sv
// back end: sector sweep with running sum, divide by 36, result register
module hslm_back #(
  parameter int LIFT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  hslm_pkg::cmd_t               q_cmd,
  input  logic signed [LIFT_WIDTH-1:0] q_lift,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_average_valid,
  output logic signed [LIFT_WIDTH-1:0] out_average_lift,
  output logic                         out_trace_clear
);

  localparam int SUM_W = LIFT_WIDTH + hslm_pkg::SECTOR_SUM_GROWTH;
  // |sum| / 36 as (|sum| >> 2) / 9; the shifted magnitude stays below 2^(LIFT_WIDTH + 3)
  localparam int MAG_W = SUM_W - hslm_pkg::AVG_PRE_SHIFT;
  localparam int N_CHUNK = (MAG_W + hslm_pkg::MUL_CHUNK_W - 1) / hslm_pkg::MUL_CHUNK_W;
  localparam int PAD_W = N_CHUNK * hslm_pkg::MUL_CHUNK_W;
  // smallest shift K >= LIFT_WIDTH + 3 with 2^K mod 9 == 8, so (2^K + 1) / 9 is exact
  localparam int RECIP_SH = ((LIFT_WIDTH + 5) / 6) * 6 + 3;
  localparam int RECIP_W = RECIP_SH - 3;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_SH) + 64'd1) / 64'd9;
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_FULL[RECIP_W-1:0];
  localparam int PART_W = hslm_pkg::MUL_CHUNK_W + RECIP_W;
  localparam int ACC_W = PAD_W + RECIP_W;
  localparam int CNT_W = 2;

  hslm_pkg::back_state_t state_r, state_nxt;

  hslm_pkg::cmd_t               cmd_r;
  logic signed [LIFT_WIDTH-1:0] lift_r;
  logic [11:0]                  h_r;
  logic                         pend_r;
  logic [5:0]                   pend_addr_r;
  logic signed [LIFT_WIDTH-1:0] rdata_r;
  logic                         rvld_r;
  logic signed [SUM_W-1:0]      sum_r, sum_nxt;
  logic                         neg_r;
  logic [PAD_W-1:0]             mag_r;
  logic [ACC_W-1:0]             acc_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_avg_valid_r;
  logic signed [LIFT_WIDTH-1:0] out_lift_r;
  logic                         out_trace_r;

  logic signed [LIFT_WIDTH-1:0] mem_r [hslm_pkg::SECTORS];
  logic [hslm_pkg::SECTORS-1:0] vld_r;

  logic signed [12:0]    delta;
  logic                  go;
  logic [5:0]            issue_addr;
  logic                  clr;
  logic                  issue;
  logic                  load_out;
  logic [SUM_W-1:0]      sum_abs;
  logic [PART_W-1:0]     part;
  logic [LIFT_WIDTH-1:0] quo;
  logic [LIFT_WIDTH-1:0] avg_full;

  // sweep test and sector of the current heading
  assign delta      = hslm_pkg::wrapped_delta(cmd_r.heading, h_r);
  assign go         = (cmd_r.left == delta[12]);
  assign issue_addr = hslm_pkg::sector_of(h_r);

  // magnitude of the sum and one chunk times the reciprocal of 9
  assign sum_abs = sum_r[SUM_W-1] ? $unsigned(-sum_r) : $unsigned(sum_r);
  assign part    = {{RECIP_W{1'b0}}, mag_r[PAD_W-1 -: hslm_pkg::MUL_CHUNK_W]} *
                   {{hslm_pkg::MUL_CHUNK_W{1'b0}}, RECIP_9};

  // signed quotient
  assign quo      = acc_r[RECIP_SH +: LIFT_WIDTH];
  assign avg_full = neg_r ? (~quo + 1'b1) : quo;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hslm_pkg::ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = hslm_pkg::ST_START;
        end
      end
      hslm_pkg::ST_START: begin
        state_nxt = hslm_pkg::ST_SWEEP;
      end
      hslm_pkg::ST_SWEEP: begin
        if (!go) begin
          state_nxt = cmd_r.north ? hslm_pkg::ST_LOAD : hslm_pkg::ST_DONE;
        end
      end
      hslm_pkg::ST_LOAD: begin
        state_nxt = hslm_pkg::ST_DIV;
      end
      hslm_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = hslm_pkg::ST_DONE;
        end
      end
      hslm_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = hslm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hslm_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    clr      = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state_r)
      hslm_pkg::ST_IDLE:  pop      = !q_empty;
      hslm_pkg::ST_START: clr      = cmd_r.clear;
      hslm_pkg::ST_SWEEP: issue    = go;
      hslm_pkg::ST_DONE:  load_out = !out_valid_r || out_ready;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hslm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command, sweep heading and sequencer registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r  <= q_cmd;
      lift_r <= q_lift;
      h_r    <= q_cmd.start;
    end else if (issue) begin
      h_r <= hslm_pkg::step_heading(h_r, cmd_r.left);
    end
    if (issue) begin
      pend_addr_r <= issue_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= issue;
    end
  end

  // sector memory: read ahead, write in the cycle after the read
  always_ff @(posedge clk) begin
    if (pend_r) begin
      mem_r[pend_addr_r] <= lift_r;
    end
    if (issue) begin
      rdata_r <= mem_r[issue_addr];
      rvld_r  <= vld_r[issue_addr];
    end
  end

  // written marks, cleared at reset and when circling ends
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (pend_r) begin
      vld_r[pend_addr_r] <= 1'b1;
    end
  end

  // running sum of all sectors
  always_comb begin
    sum_nxt = sum_r;
    if (clr) begin
      sum_nxt = '0;
    end else if (pend_r) begin
      sum_nxt = sum_r + SUM_W'(lift_r) - (rvld_r ? SUM_W'(rdata_r) : SUM_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  // quarter magnitude times the reciprocal of 9, top chunk first
  always_ff @(posedge clk) begin
    if (state_r == hslm_pkg::ST_LOAD) begin
      neg_r <= sum_r[SUM_W-1];
      mag_r <= PAD_W'(sum_abs[SUM_W-1:hslm_pkg::AVG_PRE_SHIFT]);
      acc_r <= '0;
      cnt_r <= CNT_W'(N_CHUNK - 1);
    end else if (state_r == hslm_pkg::ST_DIV) begin
      acc_r <= (acc_r << hslm_pkg::MUL_CHUNK_W) + ACC_W'(part);
      mag_r <= mag_r << hslm_pkg::MUL_CHUNK_W;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_avg_valid_r <= cmd_r.north;
      out_lift_r      <= cmd_r.north ? $signed(avg_full) : '0;
      out_trace_r     <= cmd_r.clear;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_average_valid = out_avg_valid_r;
  assign out_average_lift  = out_lift_r;
  assign out_trace_clear   = out_trace_r;

endmodule

// File: sv/heading_sector_lift_map.sv
// From acceptance, the back end sweeps and writes the sectors, then loads the result word on out_;
// a north crossing adds a load step and the chunked multiply for the mean before the result.
// Throughput: one sample at a time in the back end, bounded by the single write port of the
// sector memory and the chunked multiply; two samples can queue meanwhile.
// Reset: history, running sum and sector written marks cleared; no clearing pass.
module heading_sector_lift_map #(
  parameter int LIFT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [11:0]                  in_heading,
  input  logic signed [LIFT_WIDTH-1:0] in_lift,
  input  logic                         in_circling,
  input  logic                         in_turning_left,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_average_valid,
  output logic signed [LIFT_WIDTH-1:0] out_average_lift,
  output logic                         out_trace_clear
);

  logic                         push;
  logic                         pop;
  logic                         q_full;
  logic                         q_empty;
  hslm_pkg::cmd_t               f_cmd;
  hslm_pkg::cmd_t               q_cmd;
  logic signed [LIFT_WIDTH-1:0] f_lift;
  logic signed [LIFT_WIDTH-1:0] q_lift;

  // sample intake and classification
  hslm_front #(.LIFT_WIDTH(LIFT_WIDTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_heading     (in_heading),
    .in_lift        (in_lift),
    .in_circling    (in_circling),
    .in_turning_left(in_turning_left),
    .q_full         (q_full),
    .push           (push),
    .cmd            (f_cmd),
    .lift           (f_lift)
  );

  // command queue
  hslm_queue #(.LIFT_WIDTH(LIFT_WIDTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (f_cmd),
    .lift_in (f_lift),
    .pop     (pop),
    .cmd_out (q_cmd),
    .lift_out(q_lift),
    .full    (q_full),
    .empty   (q_empty)
  );

  // sweep, average and result
  hslm_back #(.LIFT_WIDTH(LIFT_WIDTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_cmd            (q_cmd),
    .q_lift           (q_lift),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_average_valid(out_average_valid),
    .out_average_lift (out_average_lift),
    .out_trace_clear  (out_trace_clear)
  );

  // back end only takes a command that is there
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("command taken from an empty queue");

  // a word without a north crossing carries a zero average
  a_no_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_average_valid) |-> (out_average_lift == '0))
    else $error("average lift set without a north crossing");

  // a word entering the queue leaves the queue able to report it
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !q_empty)
    else $error("queue empty right after a push");

endmodule
